// File: rtl/core/bce_pkg.sv
// ----------------------------------------------------------------------------
// Biquad cascade equalizer package
// Shared payload types, controller/datapath command and status types, and
// constants of the fixed-point format.
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam int BANDS_DEF    = 8;
    localparam int CHANNELS_DEF = 2;
    localparam int SAMPLE_BITS  = 24;

    localparam int COEF_W   = 32;
    localparam int NCOEF    = 5;
    localparam int NHIST    = 4;
    localparam int ROW_W    = NHIST * COEF_W;
    localparam int MASK_BITS = 8;
    localparam int GAIN_W   = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [23:0] GAIN_RESET = 24'd4194304;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(32'h0100_0000);

    // Input conversion to Q8.24.
    localparam int IN_LSH = (SAMPLE_BITS <= 25) ? 25 - SAMPLE_BITS : 0;
    localparam int IN_RSH = (SAMPLE_BITS > 25) ? SAMPLE_BITS - 25 : 0;
    // Output rounding of Q8.24 times Q2.22.
    localparam int OUT_SH  = 47 - SAMPLE_BITS;
    localparam int OUT_RND = 46 - SAMPLE_BITS;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'b1;

    // Multiplier operand selection.
    localparam logic [2:0] TERM_X0   = 3'd0;
    localparam logic [2:0] TERM_X1   = 3'd1;
    localparam logic [2:0] TERM_X2   = 3'd2;
    localparam logic [2:0] TERM_Y1   = 3'd3;
    localparam logic [2:0] TERM_Y2   = 3'd4;
    localparam logic [2:0] TERM_GAIN = 3'd5;

    typedef struct packed {
        logic                          op;
        logic                          channel;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [2:0]                    band;
        logic [2:0]                    coef_select;
        logic signed [31:0]            coef_value;
    } t_in_item;

    typedef struct packed {
        logic                          out_channel;
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          clipped;
    } t_out_item;

    typedef struct packed {
        logic       load_x;
        logic       coef_wr;
        logic       rd_coef;
        logic [2:0] coef_k;
        logic       rd_hist;
        logic       mul_en;
        logic [2:0] mul_term;
        logic       acc_en;
        logic       acc_first;
        logic       round_band;
        logic       hist_wr;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic band_en;
        logic out_free;
    } t_dp_stat;

endpackage

// File: rtl/core/bce_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bce_ctrl.sv
// ----------------------------------------------------------------------------
// Equalizer controller
// Sequences one request at a time: coefficient writes, the band cascade with
// its multiply-accumulate steps, the output gain and the result hand-off.
// ----------------------------------------------------------------------------
module bce_ctrl
    import bce_pkg::*;
#(
    parameter int BANDS    = BANDS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    input  t_in_item                                 i_item,
    output logic                                     o_in_stall,
    input  t_dp_stat                                 i_stat,
    output t_dp_cmd                                  o_cmd,
    output logic [((BANDS > 1) ? $clog2(BANDS) : 1)-1:0] o_band
);

    localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BAND = 2'd1;
    localparam logic [1:0] ST_GAIN = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [3:0] STEP_LAST_RD   = 4'd4;
    localparam logic [3:0] STEP_FIRST_MUL = 4'd1;
    localparam logic [3:0] STEP_LAST_MUL  = 4'd5;
    localparam logic [3:0] STEP_FIRST_ACC = 4'd2;
    localparam logic [3:0] STEP_LAST_ACC  = 4'd6;
    localparam logic [3:0] STEP_ROUND     = 4'd7;
    localparam logic [3:0] STEP_WRITE     = 4'd8;

    localparam logic [BW-1:0] LAST_BAND = BW'(BANDS - 1);

    logic [1:0]    r_state, n_state;
    logic [BW-1:0] r_band, n_band;
    logic [3:0]    r_step, n_step;
    logic [3:0]    step_m1;

    assign step_m1 = r_step - 4'd1;

    always_comb begin
        n_state = r_state;
        n_band  = r_band;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_item.op == OP_COEF) begin
                        o_cmd.coef_wr = (int'(i_item.band) < BANDS) &&
                                        (int'(i_item.coef_select) < NCOEF);
                    end else if (int'(i_item.channel) < CHANNELS) begin
                        o_cmd.load_x = 1'b1;
                        n_state      = ST_BAND;
                        n_band       = '0;
                        n_step       = '0;
                    end
                end
            end
            ST_BAND: begin
                if (!i_stat.band_en || r_step == STEP_WRITE) begin
                    o_cmd.hist_wr = i_stat.band_en;
                    n_step        = '0;
                    if (r_band == LAST_BAND) begin
                        n_state = ST_GAIN;
                    end else begin
                        n_band = r_band + BW'(1);
                    end
                end else begin
                    n_step = r_step + 4'd1;
                end
                if (i_stat.band_en) begin
                    // Coefficient k is read in step k and multiplied in the next
                    // step; its product is accumulated in the step after that.
                    o_cmd.rd_coef    = r_step <= STEP_LAST_RD;
                    o_cmd.coef_k     = r_step[2:0];
                    o_cmd.rd_hist    = r_step == '0;
                    o_cmd.mul_en     = r_step >= STEP_FIRST_MUL && r_step <= STEP_LAST_MUL;
                    o_cmd.mul_term   = step_m1[2:0];
                    o_cmd.acc_en     = r_step >= STEP_FIRST_ACC && r_step <= STEP_LAST_ACC;
                    o_cmd.acc_first  = r_step == STEP_FIRST_ACC;
                    o_cmd.round_band = r_step == STEP_ROUND;
                end
            end
            ST_GAIN: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_term = TERM_GAIN;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_band  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_band  <= n_band;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = r_state != ST_IDLE;
    assign o_band     = r_band;

endmodule

// File: rtl/core/bce_datapath.sv
// ----------------------------------------------------------------------------
// Equalizer datapath
// Configuration registers, coefficient and history memories with valid bits,
// the shared multiplier, the accumulator, rounding and the output register.
// ----------------------------------------------------------------------------
module bce_datapath
    import bce_pkg::*;
#(
    parameter int BANDS    = BANDS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                     i_cfg_index,
    input  logic [CFG_W-1:0]                         i_cfg_data,
    input  t_in_item                                 i_item,
    input  t_dp_cmd                                  i_cmd,
    input  logic [((BANDS > 1) ? $clog2(BANDS) : 1)-1:0] i_band,
    output t_dp_stat                                 o_stat,
    output logic                                     o_out_valid,
    output t_out_item                                o_out_data,
    input  logic                                     i_out_stall
);

    localparam int CDEPTH = BANDS * NCOEF;
    localparam int HDEPTH = BANDS * CHANNELS;
    localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int HAW = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;

    localparam logic signed [66:0] BAND_RND = 67'sd8388608;
    localparam logic signed [66:0] Q_MAX    = 67'sd2147483647;
    localparam logic signed [66:0] Q_MIN    = -67'sd2147483648;
    localparam logic signed [65:0] O_RND    = 66'sd1 <<< OUT_RND;
    localparam logic signed [65:0] O_MAX    = (66'sd1 <<< (SAMPLE_BITS - 1)) - 66'sd1;
    localparam logic signed [65:0] O_MIN    = -(66'sd1 <<< (SAMPLE_BITS - 1));

    logic [MASK_BITS-1:0] r_mask;
    logic [GAIN_W-1:0]    r_gain;
    logic [BANDS-1:0]     mask_ext;

    logic [CDEPTH-1:0] r_coef_vld;
    logic [HDEPTH-1:0] r_hist_vld;
    logic              r_coef_rd_vld;
    logic              r_coef_rd_k0;
    logic              r_hist_rd_vld;

    logic [CAW-1:0]    coef_waddr, coef_raddr;
    logic [HAW-1:0]    hist_row;
    logic [COEF_W-1:0] coef_rdata;
    logic [ROW_W-1:0]  hist_rdata, hist_wdata;

    logic signed [31:0] coef_eff;
    logic [ROW_W-1:0]   hist_eff;
    logic signed [31:0] x_conv;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_c;
    logic               neg_c;

    logic signed [31:0] r_x, r_y;
    logic               r_ch, r_clip;
    logic signed [65:0] r_prod;
    logic               r_neg;
    logic signed [66:0] r_acc;
    logic signed [66:0] prod_ext, prod_sgn;
    logic signed [66:0] band_sum, band_q;
    logic signed [65:0] out_sum, out_q;

    logic       r_out_vld;
    t_out_item  r_out;

    // Bands at or above the width of the mask register are never enabled.
    always_comb begin
        for (int b = 0; b < BANDS; b++) begin
            mask_ext[b] = (b < MASK_BITS) && r_mask[b % MASK_BITS];
        end
    end

    assign o_stat.band_en  = mask_ext[i_band];
    assign o_stat.out_free = !r_out_vld || !i_out_stall;

    assign coef_waddr = CAW'(int'(i_item.band) * NCOEF + int'(i_item.coef_select));
    assign coef_raddr = CAW'(int'(i_band) * NCOEF + int'(i_cmd.coef_k));
    assign hist_row   = HAW'(int'(i_band) * CHANNELS + int'(r_ch));

    bce_ram #(
        .WIDTH (COEF_W),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.coef_wr),
        .i_waddr (coef_waddr),
        .i_wdata (i_item.coef_value),
        .i_re    (i_cmd.rd_coef),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    bce_ram #(
        .WIDTH (ROW_W),
        .DEPTH (HDEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.hist_wr),
        .i_waddr (hist_row),
        .i_wdata (hist_wdata),
        .i_re    (i_cmd.rd_hist),
        .i_raddr (hist_row),
        .o_rdata (hist_rdata)
    );

    // A never written coefficient reads as its reset value, an unwritten or
    // cleared history row as zero.
    assign coef_eff = r_coef_rd_vld ? signed'(coef_rdata)
                                    : (r_coef_rd_k0 ? signed'(COEF_ONE) : 32'sd0);
    assign hist_eff = r_hist_rd_vld ? hist_rdata : '0;

    // Row layout from the low end: x1, x2, y1, y2.
    assign hist_wdata = {hist_eff[95:64], r_y, hist_eff[31:0], r_x};

    assign x_conv = (32'(i_item.sample_in) <<< IN_LSH) >>> IN_RSH;

    always_comb begin
        mul_a = 33'(coef_eff);
        neg_c = 1'b0;
        case (i_cmd.mul_term)
            TERM_X0:   mul_b = 33'(r_x);
            TERM_X1:   mul_b = 33'(signed'(hist_eff[31:0]));
            TERM_X2:   mul_b = 33'(signed'(hist_eff[63:32]));
            TERM_Y1: begin
                mul_b = 33'(signed'(hist_eff[95:64]));
                neg_c = 1'b1;
            end
            TERM_Y2: begin
                mul_b = 33'(signed'(hist_eff[127:96]));
                neg_c = 1'b1;
            end
            TERM_GAIN: begin
                mul_a = signed'({9'b0, r_gain});
                mul_b = 33'(r_x);
            end
            default:   mul_b = '0;
        endcase
    end

    assign prod_c = mul_a * mul_b;

    assign prod_ext = 67'(r_prod);
    assign prod_sgn = r_neg ? -prod_ext : prod_ext;

    assign band_sum = r_acc + BAND_RND;
    assign band_q   = band_sum >>> 24;
    assign out_sum  = r_prod + O_RND;
    assign out_q    = out_sum >>> OUT_SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '0;
            r_gain     <= GAIN_RESET;
            r_coef_vld <= '0;
            r_hist_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MASK: begin
                        r_mask <= i_cfg_data[MASK_BITS-1:0];
                        // History of every band left disabled is cleared.
                        for (int b = 0; b < BANDS; b++) begin
                            for (int c = 0; c < CHANNELS; c++) begin
                                if (!((b < MASK_BITS) && i_cfg_data[b % MASK_BITS])) begin
                                    r_hist_vld[b * CHANNELS + c] <= 1'b0;
                                end
                            end
                        end
                    end
                    CFG_GAIN: r_gain <= i_cfg_data[GAIN_W-1:0];
                endcase
            end
            if (i_cmd.coef_wr) begin
                r_coef_vld[coef_waddr] <= 1'b1;
            end
            if (i_cmd.hist_wr) begin
                r_hist_vld[hist_row] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_coef) begin
            r_coef_rd_vld <= r_coef_vld[coef_raddr];
            r_coef_rd_k0  <= i_cmd.coef_k == '0;
        end
        if (i_cmd.rd_hist) begin
            r_hist_rd_vld <= r_hist_vld[hist_row];
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod_c;
            r_neg  <= neg_c;
        end
        if (i_cmd.acc_en) begin
            r_acc <= i_cmd.acc_first ? prod_sgn : r_acc + prod_sgn;
        end
        if (i_cmd.load_x) begin
            r_x    <= x_conv;
            r_ch   <= i_item.channel;
            r_clip <= 1'b0;
        end else if (i_cmd.round_band) begin
            if (band_q > Q_MAX) begin
                r_y    <= 32'sh7fff_ffff;
                r_clip <= 1'b1;
            end else if (band_q < Q_MIN) begin
                r_y    <= -32'sh8000_0000;
                r_clip <= 1'b1;
            end else begin
                r_y <= band_q[31:0];
            end
        end else if (i_cmd.hist_wr) begin
            r_x <= r_y;
        end
        if (i_cmd.out_load) begin
            r_out.out_channel <= r_ch;
            if (out_q > O_MAX) begin
                r_out.sample_out <= O_MAX[SAMPLE_BITS-1:0];
                r_out.clipped    <= 1'b1;
            end else if (out_q < O_MIN) begin
                r_out.sample_out <= O_MIN[SAMPLE_BITS-1:0];
                r_out.clipped    <= 1'b1;
            end else begin
                r_out.sample_out <= out_q[SAMPLE_BITS-1:0];
                r_out.clipped    <= r_clip;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: rtl/core/biquad_cascade_equalizer_top.sv
// ----------------------------------------------------------------------------
// Biquad cascade equalizer
// Up to eight direct-form-I biquad bands per channel, output gain, saturation.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one request at a time. A coefficient request
// writes one coefficient, is taken without a stall and yields no result. An
// audio request holds off further requests (o_in_stall high) until its result
// has been loaded into the output register; a request for a channel beyond
// CHANNELS is dropped without a result.
// The single shared 33 x 33 multiplier performs the five products of each
// enabled band in turn, between the read, round and history write-back
// steps of that band, and then the output gain product.
// The output register holds a finished result while i_out_stall is high;
// the next audio request is accepted meanwhile, and its result waits in
// the controller until the register is free.
// Reset (synchronous, active low) restores the band mask to zero, the gain
// to unity, every coefficient to its default (b0 = 1.0) and clears all
// filter history. Configuration must be written only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module biquad_cascade_equalizer_top
    import bce_pkg::*;
#(
    parameter int BANDS    = BANDS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output t_out_item            o_out_data,
    input  logic                 i_out_stall
);

    localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

    t_dp_cmd       dp_cmd;
    t_dp_stat      dp_stat;
    logic [BW-1:0] band;

    bce_ctrl #(
        .BANDS    (BANDS),
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (i_in_data),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_band     (band)
    );

    bce_datapath #(
        .BANDS    (BANDS),
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_data),
        .i_cmd       (dp_cmd),
        .i_band      (band),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // A result is only produced after the controller has left idle.
    a_rise_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while the controller was idle");

    // An accepted request never yields a result in the very next cycle.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after a request");

    // The history write-back always follows the rounding of that band.
    a_wb_after_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.hist_wr |-> $past(dp_cmd.round_band))
        else $error("history written without a rounded band output");

    // A stalled result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("output register loaded while a result was stalled");

endmodule
